>>> sv/jitf_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and saturation helper of the joint torque filter
package jitf_pkg;

    localparam int JW     = 3;
    localparam int DW     = 32;
    localparam int KW     = 17;
    localparam int LW     = 31;
    localparam int CFG_IW = 3;

    localparam logic [CFG_IW-1:0] CFG_MODE = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_KEEP = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_GSEL = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_STF  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_DMP  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_LIM  = 3'd5;

    localparam logic [KW-1:0] KEEP_RST  = 17'd6554;
    localparam logic [KW-1:0] ONE_Q16   = 17'd65536;
    localparam logic [LW-1:0] LIMIT_RST = 31'd327680;

    typedef struct packed {
        logic [JW-1:0]        joint;
        logic signed [DW-1:0] lp;
        logic signed [DW-1:0] lv;
        logic signed [DW-1:0] fp;
        logic signed [DW-1:0] fv;
        logic signed [DW-1:0] ft;
        logic                 known;
    } t_item;

    typedef struct packed {
        logic signed [DW-1:0] stf;
        logic signed [DW-1:0] dmp;
        logic [LW-1:0]        lim;
    } t_gain;

    typedef struct packed {
        logic                 we_stf;
        logic                 we_dmp;
        logic                 we_lim;
        logic [DW-1:0]        data;
    } t_gain_wr;

    typedef struct packed {
        logic signed [DW-1:0] raw;
        logic signed [DW-1:0] filt;
        logic                 seeded;
    } t_state;

    typedef struct packed {
        logic                 mode;
        logic [KW-1:0]        keep;
    } t_cfg;

    typedef struct packed {
        logic [JW-1:0]        joint;
        logic signed [DW-1:0] cmd;
        logic                 limited;
    } t_result;

    function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[DW-1:0];
        end
    endfunction

endpackage

>>> sv/joint_impedance_torque_filter_core.sv
`timescale 1ns / 1ps
// top level of the joint impedance torque filter with low-pass and clamp
//
// channel   direction  handshake                        content
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  one control tick of one joint
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  torque command of that joint
// cfg       in         i_cfg_valid/o_cfg_ready          register index and write data
//
// a command passes through the pipeline stages and the output register before it is valid on m_axis
// requests for different joints are taken one per cycle while no stage stalls; a joint still
// in the pipeline holds the next request for it until its write-back, so the rate of one joint is
// set by the read-modify-write loop through the per-joint state memory
// after reset the tables read as their reset values through per-entry valid bits, no sweep
// each stage moves when the next one is free; the output register holds while m_axis stalls
module joint_impedance_torque_filter_core #(
    parameter int JOINTS = 7
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // joint, leader_pos, leader_vel, follower_pos, follower_vel, follower_torque, pad
    input  logic [167:0] i_s_axis_tdata,
    // follower_known
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // joint_out, torque_command, pad
    output logic [39:0]  o_m_axis_tdata,
    // limited
    output logic         o_m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import jitf_pkg::*;

    localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    logic          r_mode;
    logic [KW-1:0] r_keep;
    logic [JW-1:0] r_gsel;

    logic          n_cfg_wr;
    logic          n_gsel_ok;
    t_gain_wr      n_gain_wr;
    t_cfg          n_cfg;
    t_item         n_item;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_gain         rd_gain;
    t_state        rd_state;
    logic          st_we;
    logic [AW-1:0] st_addr;
    t_state        st_data;
    t_result       result;

    assign o_cfg_ready = 1'b1;
    assign n_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign n_gsel_ok   = 32'(r_gsel) < JOINTS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_keep <= KEEP_RST;
            r_gsel <= '0;
        end else if (n_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_MODE: r_mode <= i_cfg_data[0];
                CFG_KEEP: r_keep <= i_cfg_data[KW-1:0];
                CFG_GSEL: r_gsel <= i_cfg_data[JW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_gain_wr.we_stf = n_cfg_wr && n_gsel_ok && (i_cfg_index == CFG_STF);
        n_gain_wr.we_dmp = n_cfg_wr && n_gsel_ok && (i_cfg_index == CFG_DMP);
        n_gain_wr.we_lim = n_cfg_wr && n_gsel_ok && (i_cfg_index == CFG_LIM);
        n_gain_wr.data   = i_cfg_data;
        n_cfg.mode       = r_mode;
        n_cfg.keep       = r_keep;
    end

    always_comb begin
        n_item.joint = i_s_axis_tdata[2:0];
        n_item.lp    = $signed(i_s_axis_tdata[34:3]);
        n_item.lv    = $signed(i_s_axis_tdata[66:35]);
        n_item.fp    = $signed(i_s_axis_tdata[98:67]);
        n_item.fv    = $signed(i_s_axis_tdata[130:99]);
        n_item.ft    = $signed(i_s_axis_tdata[162:131]);
        n_item.known = i_s_axis_tuser;
    end

    jitf_mem #(
        .JOINTS(JOINTS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_gain     (rd_gain),
        .o_state    (rd_state),
        .i_gain_wr  (n_gain_wr),
        .i_gain_addr(AW'(r_gsel)),
        .i_st_we    (st_we),
        .i_st_addr  (st_addr),
        .i_st_data  (st_data)
    );

    jitf_pipe #(
        .JOINTS(JOINTS)
    ) u_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (n_cfg),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_item     (n_item),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_gain     (rd_gain),
        .i_state    (rd_state),
        .o_st_we    (st_we),
        .o_st_addr  (st_addr),
        .o_st_data  (st_data),
        .o_out_valid(o_m_axis_tvalid),
        .i_out_ready(i_m_axis_tready),
        .o_result   (result)
    );

    assign o_m_axis_tdata = {5'b00000, result.cmd, result.joint};
    assign o_m_axis_tuser = result.limited;

endmodule

>>> sv/jitf_mem.sv
`timescale 1ns / 1ps
// per-joint gain table and filter state memory with reset valid bits
module jitf_mem #(
    parameter int JOINTS = 7,
    localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output jitf_pkg::t_gain    o_gain,
    output jitf_pkg::t_state   o_state,
    input  jitf_pkg::t_gain_wr i_gain_wr,
    input  logic [AW-1:0]      i_gain_addr,
    input  logic               i_st_we,
    input  logic [AW-1:0]      i_st_addr,
    input  jitf_pkg::t_state   i_st_data
);
    import jitf_pkg::*;

    logic signed [DW-1:0] r_stf_mem [JOINTS];
    logic signed [DW-1:0] r_dmp_mem [JOINTS];
    logic [LW-1:0]        r_lim_mem [JOINTS];
    t_state               r_st_mem  [JOINTS];

    logic [JOINTS-1:0]    r_stf_vld;
    logic [JOINTS-1:0]    r_dmp_vld;
    logic [JOINTS-1:0]    r_lim_vld;
    logic [JOINTS-1:0]    r_st_vld;

    logic signed [DW-1:0] r_rd_stf;
    logic signed [DW-1:0] r_rd_dmp;
    logic [LW-1:0]        r_rd_lim;
    t_state               r_rd_st;
    logic                 r_rd_stf_vld;
    logic                 r_rd_dmp_vld;
    logic                 r_rd_lim_vld;
    logic                 r_rd_st_vld;

    always_ff @(posedge i_clk) begin
        if (i_gain_wr.we_stf) begin
            r_stf_mem[i_gain_addr] <= $signed(i_gain_wr.data);
        end
        if (i_gain_wr.we_dmp) begin
            r_dmp_mem[i_gain_addr] <= $signed(i_gain_wr.data);
        end
        if (i_gain_wr.we_lim) begin
            r_lim_mem[i_gain_addr] <= i_gain_wr.data[LW-1:0];
        end
        if (i_st_we) begin
            r_st_mem[i_st_addr] <= i_st_data;
        end
        if (i_rd_en) begin
            r_rd_stf <= r_stf_mem[i_rd_addr];
            r_rd_dmp <= r_dmp_mem[i_rd_addr];
            r_rd_lim <= r_lim_mem[i_rd_addr];
            r_rd_st  <= r_st_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stf_vld    <= '0;
            r_dmp_vld    <= '0;
            r_lim_vld    <= '0;
            r_st_vld     <= '0;
            r_rd_stf_vld <= 1'b0;
            r_rd_dmp_vld <= 1'b0;
            r_rd_lim_vld <= 1'b0;
            r_rd_st_vld  <= 1'b0;
        end else begin
            if (i_gain_wr.we_stf) begin
                r_stf_vld[i_gain_addr] <= 1'b1;
            end
            if (i_gain_wr.we_dmp) begin
                r_dmp_vld[i_gain_addr] <= 1'b1;
            end
            if (i_gain_wr.we_lim) begin
                r_lim_vld[i_gain_addr] <= 1'b1;
            end
            if (i_st_we) begin
                r_st_vld[i_st_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_stf_vld <= r_stf_vld[i_rd_addr];
                r_rd_dmp_vld <= r_dmp_vld[i_rd_addr];
                r_rd_lim_vld <= r_lim_vld[i_rd_addr];
                r_rd_st_vld  <= r_st_vld[i_rd_addr];
            end
        end
    end

    always_comb begin
        o_gain.stf = r_rd_stf_vld ? r_rd_stf : '0;
        o_gain.dmp = r_rd_dmp_vld ? r_rd_dmp : '0;
        o_gain.lim = r_rd_lim_vld ? r_rd_lim : LIMIT_RST;
        o_state    = r_rd_st_vld ? r_rd_st : '0;
    end

endmodule

>>> sv/jitf_pipe.sv
`timescale 1ns / 1ps
// torque pipeline: error, gain products, raw select, low-pass, clamp and halve
module jitf_pipe #(
    parameter int JOINTS = 7,
    localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jitf_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  jitf_pkg::t_item   i_item,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    input  jitf_pkg::t_gain   i_gain,
    input  jitf_pkg::t_state  i_state,
    output logic              o_st_we,
    output logic [AW-1:0]     o_st_addr,
    output jitf_pkg::t_state  o_st_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output jitf_pkg::t_result o_result
);
    import jitf_pkg::*;

    localparam int NS = 8;

    logic [NS:1]          r_vld;
    logic [NS+1:1]        rdy;
    logic [JW-1:0]        r_jnt [1:NS];
    logic                 r_ok  [1:NS];
    logic                 r_out_vld;
    t_result              r_out;

    logic                 n_conflict;
    logic                 n_in_ok;
    logic                 n_acc;

    // stage 1
    logic signed [DW-1:0] r1_lp, r1_lv, r1_fp, r1_fv, r1_ft;
    logic                 r1_known;
    // stage 2
    logic signed [DW-1:0] r2_pe, r2_ve, r2_stf, r2_dmp, r2_ft;
    logic [LW-1:0]        r2_lim;
    t_state               r2_st;
    logic                 r2_known;
    // stage 3
    logic signed [63:0]   r3_ps, r3_pd;
    logic signed [DW-1:0] r3_ft;
    logic [LW-1:0]        r3_lim;
    t_state               r3_st;
    logic                 r3_known;
    // stage 4
    logic signed [DW-1:0] r4_gs, r4_gd, r4_ft;
    logic [LW-1:0]        r4_lim;
    t_state               r4_st;
    logic                 r4_known;
    // stage 5
    logic signed [DW-1:0] r5_raw, r5_prev;
    logic                 r5_seed;
    logic [LW-1:0]        r5_lim;
    // stage 6
    logic signed [49:0]   r6_p1, r6_p2;
    logic signed [DW-1:0] r6_raw;
    logic                 r6_seed;
    logic [LW-1:0]        r6_lim;
    // stage 7
    logic signed [50:0]   r7_acc;
    logic signed [DW-1:0] r7_raw;
    logic                 r7_seed;
    logic [LW-1:0]        r7_lim;
    // stage 8
    logic signed [DW-1:0] r8_f;
    logic signed [DW-1:0] r8_raw;
    logic                 r8_seed;
    logic [LW-1:0]        r8_lim;

    logic signed [32:0]   n_pe, n_ve, n_gsum;
    logic signed [63:0]   n_ps_rnd, n_pd_rnd;
    logic signed [DW-1:0] n_raw_new;
    logic [KW-1:0]        n_keep, n_kc;
    logic signed [32:0]   n_f33, n_lp33, n_ln33;
    logic signed [DW-1:0] n_clamp;
    logic                 n_lim_flag;

    always_comb begin
        rdy[NS+1] = !r_out_vld || i_out_ready;
        for (int k = NS; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    // same-joint items wait until the earlier one has written back
    always_comb begin
        n_conflict = 1'b0;
        for (int k = 1; k <= NS; k++) begin
            if (r_vld[k] && r_ok[k] && (r_jnt[k] == i_item.joint)) begin
                n_conflict = 1'b1;
            end
        end
    end

    assign n_in_ok    = 32'(i_item.joint) < JOINTS;
    assign o_in_ready = rdy[1] && !n_conflict;
    assign n_acc      = i_in_valid && o_in_ready;
    assign o_rd_en    = n_acc && n_in_ok;
    assign o_rd_addr  = AW'(i_item.joint);

    always_comb begin
        n_pe      = 33'(r1_lp) - 33'(r1_fp);
        n_ve      = 33'(r1_lv) - 33'(r1_fv);
        n_ps_rnd  = (r3_ps + 64'sd32768) >>> 16;
        n_pd_rnd  = (r3_pd + 64'sd32768) >>> 16;
        n_gsum    = 33'(r4_gs) + 33'(r4_gd);
        n_raw_new = i_cfg.mode ? sat32(64'(n_gsum)) : r4_ft;
        n_keep    = (i_cfg.keep > ONE_Q16) ? ONE_Q16 : i_cfg.keep;
        n_kc      = ONE_Q16 - n_keep;
        n_f33     = 33'(r8_f);
        n_lp33    = $signed({2'b00, r8_lim});
        n_ln33    = -n_lp33;
        if (n_f33 > n_lp33) begin
            n_clamp    = $signed({1'b0, r8_lim});
            n_lim_flag = 1'b1;
        end else if (n_f33 < n_ln33) begin
            n_clamp    = n_ln33[DW-1:0];
            n_lim_flag = 1'b1;
        end else begin
            n_clamp    = r8_f;
            n_lim_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (rdy[1]) begin
                r_vld[1] <= n_acc;
            end
            for (int k = 2; k <= NS; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (rdy[NS+1]) begin
                r_out_vld <= r_vld[NS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_acc) begin
            r_jnt[1] <= i_item.joint;
            r_ok[1]  <= n_in_ok;
            r1_lp    <= i_item.lp;
            r1_lv    <= i_item.lv;
            r1_fp    <= i_item.fp;
            r1_fv    <= i_item.fv;
            r1_ft    <= i_item.ft;
            r1_known <= i_item.known;
        end
        for (int k = 2; k <= NS; k++) begin
            if (rdy[k] && r_vld[k-1]) begin
                r_jnt[k] <= r_jnt[k-1];
                r_ok[k]  <= r_ok[k-1];
            end
        end
        if (rdy[2] && r_vld[1]) begin
            r2_pe    <= sat32(64'(n_pe));
            r2_ve    <= sat32(64'(n_ve));
            r2_stf   <= i_gain.stf;
            r2_dmp   <= i_gain.dmp;
            r2_lim   <= i_gain.lim;
            r2_st    <= i_state;
            r2_ft    <= r1_ft;
            r2_known <= r1_known;
        end
        if (rdy[3] && r_vld[2]) begin
            r3_ps    <= r2_stf * r2_pe;
            r3_pd    <= r2_dmp * r2_ve;
            r3_ft    <= r2_ft;
            r3_lim   <= r2_lim;
            r3_st    <= r2_st;
            r3_known <= r2_known;
        end
        if (rdy[4] && r_vld[3]) begin
            r4_gs    <= sat32(n_ps_rnd);
            r4_gd    <= sat32(n_pd_rnd);
            r4_ft    <= r3_ft;
            r4_lim   <= r3_lim;
            r4_st    <= r3_st;
            r4_known <= r3_known;
        end
        if (rdy[5] && r_vld[4]) begin
            if (r4_known) begin
                r5_raw  <= n_raw_new;
                r5_prev <= r4_st.seeded ? r4_st.filt : n_raw_new;
                r5_seed <= 1'b1;
            end else begin
                r5_raw  <= r4_st.raw;
                r5_prev <= r4_st.filt;
                r5_seed <= r4_st.seeded;
            end
            r5_lim <= r4_lim;
        end
        if (rdy[6] && r_vld[5]) begin
            r6_p1   <= $signed({1'b0, n_keep}) * r5_prev;
            r6_p2   <= $signed({1'b0, n_kc}) * r5_raw;
            r6_raw  <= r5_raw;
            r6_seed <= r5_seed;
            r6_lim  <= r5_lim;
        end
        if (rdy[7] && r_vld[6]) begin
            r7_acc  <= 51'(r6_p1) + 51'(r6_p2) + 51'sd32768;
            r7_raw  <= r6_raw;
            r7_seed <= r6_seed;
            r7_lim  <= r6_lim;
        end
        if (rdy[8] && r_vld[7]) begin
            r8_f    <= sat32(64'(r7_acc >>> 16));
            r8_raw  <= r7_raw;
            r8_seed <= r7_seed;
            r8_lim  <= r7_lim;
        end
        if (rdy[NS+1] && r_vld[NS]) begin
            r_out.joint <= r_jnt[NS];
            if (r_ok[NS]) begin
                r_out.cmd     <= n_clamp / 32'sd2;
                r_out.limited <= n_lim_flag;
            end else begin
                r_out.cmd     <= '0;
                r_out.limited <= 1'b0;
            end
        end
    end

    assign o_st_we          = r_vld[NS] && rdy[NS+1] && r_ok[NS];
    assign o_st_addr        = AW'(r_jnt[NS]);
    assign o_st_data.raw    = r8_raw;
    assign o_st_data.filt   = r8_f;
    assign o_st_data.seeded = r8_seed;

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

endmodule
